FILE: hdl/sliding_window_event_rate_limiter_assert.svh
// ----------------------------------------------------------------------------
// sliding window event rate limiter assertion macros
// concurrent checks that compile away in synthesis builds
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EVENT_RATE_LIMITER_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_RATE_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SWRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swrl same-cycle check failed");

// next-cycle implication
`define SWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swrl next-cycle check failed");

`else

`define SWRL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl package
// widths, reset values, register indexes and controller/datapath structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrl_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam int TIME_W   = 32;
  localparam int WINDOW_W = 16;
  localparam int LIMIT_W  = 6;
  localparam int COUNT_W  = 6;
  localparam int TOTAL_W  = 16;

  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [WINDOW_W-1:0] WINDOW_RST = WINDOW_W'(2000);
  localparam logic [LIMIT_W-1:0]  WARN_RST   = LIMIT_W'(20);
  localparam logic [LIMIT_W-1:0]  KICK_RST   = LIMIT_W'(30);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_WARN   = 2'd1,
    CFG_KICK   = 2'd2
  } swrl_cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // write event time at head, capture it
    logic read_tail;  // fetch ring entry at tail
    logic step_tail;  // tail entry aged out, move past it
    logic finish;     // decide, update indexes, load result
  } swrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tail_at_head;
    logic too_old;
    logic out_free;
  } swrl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/swrl_ifs.sv
// ----------------------------------------------------------------------------
// swrl channel interfaces
// valid/ready channels for event items and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swrl_in_if;
  import swrl_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

interface swrl_out_if;
  import swrl_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] recent_count;
  logic               warn_flag;
  logic               kick_flag;
  logic [TOTAL_W-1:0] warning_total;

  modport source (output valid, output recent_count, output warn_flag,
                  output kick_flag, output warning_total, input ready);
  modport sink   (input valid, input recent_count, input warn_flag,
                  input kick_flag, input warning_total, output ready);
endinterface

`default_nettype wire

FILE: hdl/swrl_ctrl.sv
// ----------------------------------------------------------------------------
// swrl controller
// sequences accept, tail walk over the ring and the final decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output swrl_pkg::swrl_cmd_t    cmd,
  input  wire swrl_pkg::swrl_sts_t sts
);
  import swrl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (sts.tail_at_head) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.read_tail = 1'b1;
          state_nxt     = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.too_old) begin
          cmd.step_tail = 1'b1;
          state_nxt     = S_READ;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // hold until the result register can take the item
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/swrl_dp.sv
// ----------------------------------------------------------------------------
// swrl datapath
// timestamp ring, head/tail indexes, age compare, counter and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrl_dp #(
  parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swrl_pkg::swrl_cmd_t           cmd,
  output swrl_pkg::swrl_sts_t                sts,
  input  wire logic [swrl_pkg::TIME_W-1:0]   in_time,
  input  wire logic [swrl_pkg::WINDOW_W-1:0] window_ms,
  input  wire logic [swrl_pkg::LIMIT_W-1:0]  warn_limit,
  input  wire logic [swrl_pkg::LIMIT_W-1:0]  kick_limit,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [swrl_pkg::COUNT_W-1:0]       out_recent_count,
  output logic                               out_warn_flag,
  output logic                               out_kick_flag,
  output logic [swrl_pkg::TOTAL_W-1:0]       out_warning_total
);
  import swrl_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CMP_W = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(RING_DEPTH);
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((1 << COUNT_W) - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  logic [TIME_W-1:0] ring [RING_DEPTH];
  logic [TIME_W-1:0] rd_data_r;
  logic [TIME_W-1:0] now_r;

  logic [IDX_W-1:0]   head_r;
  logic [IDX_W-1:0]   tail_r;
  logic [TOTAL_W-1:0] warn_cnt_r;
  logic               out_valid_r;

  logic [IDX_W:0]     diff_ext;
  logic [CMP_W-1:0]   count;
  logic               kick;
  logic               warn;
  logic [IDX_W-1:0]   head_adv;
  logic [TOTAL_W-1:0] warn_cnt_nxt;
  logic [TIME_W-1:0]  age;

  // ring memory: one write port at head, one registered read port at tail
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[head_r] <= in_time;
      now_r        <= in_time;
    end
    if (cmd.read_tail) begin
      rd_data_r <= ring[tail_r];
    end
  end

  assign age = now_r - rd_data_r;

  assign sts.tail_at_head = (tail_r == head_r);
  assign sts.too_old      = (age > {{(TIME_W - WINDOW_W){1'b0}}, window_ms});
  assign sts.out_free     = !out_valid_r || out_ready;

  // entries from tail up to head, modulo depth
  assign diff_ext = {1'b0, head_r} + ((head_r < tail_r) ? DEPTH_EXT : '0) - {1'b0, tail_r};
  assign count    = CMP_W'(diff_ext[IDX_W-1:0]);

  assign kick     = count > CMP_W'(kick_limit);
  assign warn     = !kick && (count > CMP_W'(warn_limit));
  assign head_adv = ring_next(head_r);
  assign warn_cnt_nxt = (warn && warn_cnt_r != TOTAL_MAX) ? warn_cnt_r + 1'b1 : warn_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      warn_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.step_tail) begin
        tail_r <= ring_next(tail_r);
      end
      if (cmd.finish) begin
        warn_cnt_r <= warn_cnt_nxt;
        if (!kick) begin
          head_r <= head_adv;
          // ring full: drop the oldest entry
          if (head_adv == tail_r) begin
            tail_r <= ring_next(tail_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_recent_count  <= (count > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : count[COUNT_W-1:0];
      out_warn_flag     <= warn;
      out_kick_flag     <= kick;
      out_warning_total <= warn_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/sliding_window_event_rate_limiter.sv
// ----------------------------------------------------------------------------
// sliding window event rate limiter
// top level: configuration registers, controller and datapath
// ----------------------------------------------------------------------------
// Each item carries a free-running millisecond timestamp. It is stored in a
// ring of RING_DEPTH entries at the head, then the tail walks past stored
// entries older than window_ms (unsigned 32-bit age), and one result item
// reports how many earlier events are still in the window. A count above
// kick_limit raises kick_flag and keeps the head in place, so the next event
// overwrites the slot; otherwise the head advances, and a count above
// warn_limit raises warn_flag and bumps a saturating 16-bit warning total.
// The ring memory has one registered read port, and the tail walk takes a
// read step and then an age compare step for each entry; it stops at an
// entry still inside the window or when it reaches the head. No new event
// is accepted until the block is back in idle after the decision. The
// result sits in an output register, and the block waits in the decision
// step only while that register still holds an earlier, untaken result.
// Configuration should be written through cfg_we/cfg_addr/cfg_wdata
// (0 window_ms, 1 warn_limit, 2 kick_limit) only while the block is idle;
// the block itself does not enforce this. Other addresses are ignored. The
// ring needs no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_event_rate_limiter_assert.svh"

module sliding_window_event_rate_limiter #(
  parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  swrl_in_if.sink                              in_ch,
  swrl_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [swrl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [swrl_pkg::CFG_W-1:0]      cfg_wdata
);
  import swrl_pkg::*;

  // configuration registers
  logic [WINDOW_W-1:0] window_r;
  logic [LIMIT_W-1:0]  warn_limit_r;
  logic [LIMIT_W-1:0]  kick_limit_r;

  // controller <-> datapath
  swrl_cmd_t cmd;
  swrl_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= WINDOW_RST;
      warn_limit_r <= WARN_RST;
      kick_limit_r <= KICK_RST;
    end else if (cfg_we) begin
      unique case (swrl_cfg_t'(cfg_addr))
        CFG_WINDOW: window_r     <= cfg_wdata[WINDOW_W-1:0];
        CFG_WARN:   warn_limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_KICK:   kick_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // sequencer: accept, tail walk, decision
  swrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // ring, indexes, compare and result register
  swrl_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_time           (in_ch.event_time),
    .window_ms         (window_r),
    .warn_limit        (warn_limit_r),
    .kick_limit        (kick_limit_r),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_recent_count  (out_ch.recent_count),
    .out_warn_flag     (out_ch.warn_flag),
    .out_kick_flag     (out_ch.kick_flag),
    .out_warning_total (out_ch.warning_total)
  );

  // one item at a time: no accept right after an accept
  `SWRL_ASSERT_NEXT(a_single_item, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // a decision always lands a result in the output register
  `SWRL_ASSERT_NEXT(a_finish_to_out, clk, rst_n, cmd.finish, out_ch.valid)
  // a decision never overwrites an untaken result
  `SWRL_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.finish, !out_ch.valid || out_ch.ready)
  // kick and warning are exclusive
  `SWRL_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_ch.valid, !(out_ch.warn_flag && out_ch.kick_flag))

endmodule

`default_nettype wire
